/* design/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg - escape sequence decoder package
// Parse mode codes, character constants, result entry type and the
// hex digit decode helper.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

    // Parser mode; unused codes behave as MODE_NORMAL
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_OCT    = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_UNI    = 3'd4
    } t_mode;

    // One result entry
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_res;

    // Escape characters
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_V      = 8'h76;
    localparam logic [7:0] CHR_A      = 8'h61;
    localparam logic [7:0] CHR_X      = 8'h78;
    localparam logic [7:0] CHR_U      = 8'h75;

    // Control bytes produced by the letter escapes
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_BEL = 8'h07;

    // Sizes
    localparam int MAX_RES  = 6;   // results per transaction
    localparam int NUM_CAND = 11;  // candidate slots before compaction
    localparam int RAW_DIG  = 3;   // stored hex digits for replay
    localparam int Q_DEPTH  = 12;  // result queue entries

    // Hex digit decode: {ok, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/escape_sequence_decoder.sv */
// ----------------------------------------------------------------------------
// escape_sequence_decoder - C-style backslash escape decoder
// Decodes one raw character per transaction into zero to six result bytes,
// held in a shift queue that drains one result per cycle while i_ready is high.
// ----------------------------------------------------------------------------
// The first result of a transaction is registered into the result queue and
// appears in the cycle after its input is taken, later when older results
// are still queued ahead. Throughput: one input per cycle while at most six
// results are queued; the 12-entry result queue drains one result per cycle
// while i_ready is high, so a replay burst of up to six results can stall input.
// Reset: parser returns to normal mode and the result queue is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    // output channel
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_out_last
);

    // parser state
    t_mode        r_mode, n_mode;
    logic [1:0]   r_dc, n_dc;
    logic [7:0]   r_acc, n_acc;
    logic         r_fol, n_fol;
    logic [7:0]   r_raw [RAW_DIG];
    logic [7:0]   n_raw [RAW_DIG];

    // result queue
    t_res         r_q [Q_DEPTH];
    t_res         n_q [Q_DEPTH];
    logic [3:0]   r_cnt, n_cnt;

    logic         accept, pop;
    logic [7:0]   c;

    // character decode
    logic         c_bs, c_oct, hex_ok, ctrl_hit, oct_done, hex_done, pass_c;
    logic [3:0]   hex_val;
    logic [7:0]   ctrl_byte;
    logic [2:0]   dc_inc;

    // candidates and compaction
    logic [7:0]          cand [NUM_CAND];
    logic [NUM_CAND-1:0] cval;
    logic [3:0]          pos  [NUM_CAND];
    t_res                nres [MAX_RES];
    logic [2:0]          n_new;
    logic [3:0]          base;

    assign c      = i_in_byte;
    assign o_ready = (r_cnt <= 4'(MAX_RES));
    assign accept = i_valid & o_ready;
    assign o_valid = (r_cnt != 4'd0);
    assign pop    = o_valid & i_ready;

    assign o_out_byte = r_q[0].data;
    assign o_has_byte = r_q[0].has;
    assign o_out_last = r_q[0].last;

    // character classes
    always_comb begin
        c_bs    = (c == CHR_BSLASH);
        c_oct   = c inside {[8'h30:8'h37]};
        {hex_ok, hex_val} = hex_nibble(c);
        dc_inc  = {1'b0, r_dc} + 3'd1;
        oct_done = r_fol ? (dc_inc >= 3'd3) : (dc_inc >= 3'd2);
        hex_done = (r_mode == MODE_HEX) ? (dc_inc >= 3'd2) : (dc_inc >= 3'd4);
        ctrl_hit  = 1'b1;
        case (c)
            CHR_R:   ctrl_byte = CTL_CR;
            CHR_N:   ctrl_byte = CTL_LF;
            CHR_T:   ctrl_byte = CTL_TAB;
            CHR_V:   ctrl_byte = CTL_VT;
            CHR_A:   ctrl_byte = CTL_BEL;
            default: begin
                ctrl_byte = 8'h00;
                ctrl_hit  = 1'b0;
            end
        endcase
    end

    // next parser state (before end-of-string flush)
    always_comb begin
        n_mode = r_mode;
        n_dc   = r_dc;
        n_acc  = r_acc;
        n_fol  = r_fol;
        n_raw  = r_raw;
        pass_c = 1'b0;
        case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                if (c == CHR_X || c == CHR_U) begin
                    n_mode = (c == CHR_X) ? MODE_HEX : MODE_UNI;
                    n_dc   = 2'd0;
                    n_acc  = 8'h00;
                end else if (c_oct) begin
                    n_mode = MODE_OCT;
                    n_acc  = {5'd0, c[2:0]};
                    n_dc   = 2'd1;
                    n_fol  = ~c[2];
                end
            end
            MODE_OCT: begin
                if (c_oct) begin
                    n_acc = {r_acc[4:0], c[2:0]};
                    n_dc  = dc_inc[1:0];
                    if (oct_done) begin
                        n_mode = MODE_NORMAL;
                    end
                end else begin
                    pass_c = 1'b1;
                end
            end
            MODE_HEX, MODE_UNI: begin
                if (hex_ok) begin
                    n_acc = {r_acc[3:0], hex_val};
                    if (hex_done) begin
                        n_mode = MODE_NORMAL;
                    end else begin
                        n_raw[r_dc] = c;
                        n_dc        = dc_inc[1:0];
                    end
                end else begin
                    pass_c = 1'b1;
                end
            end
            default: begin
                pass_c = 1'b1;
            end
        endcase
        // character handled as ordinary text
        if (pass_c) begin
            n_mode = c_bs ? MODE_ESC : MODE_NORMAL;
        end
    end

    // candidate result bytes: escape phase 0..4, plain char 5, flush 6..10
    always_comb begin
        for (int i = 0; i < NUM_CAND; i++) begin
            cand[i] = 8'h00;
        end
        case (r_mode)
            MODE_ESC: begin
                if (c_bs) begin
                    cand[0] = CHR_BSLASH;
                end else if (ctrl_hit) begin
                    cand[0] = ctrl_byte;
                end else if (!(c == CHR_X || c == CHR_U || c_oct)) begin
                    cand[0] = CHR_BSLASH;
                    cand[1] = c;
                end
            end
            MODE_OCT: begin
                if (!c_oct) begin
                    cand[0] = r_acc;
                end else if (oct_done) begin
                    cand[0] = n_acc;
                end
            end
            MODE_HEX, MODE_UNI: begin
                if (hex_ok) begin
                    if (hex_done) begin
                        cand[0] = n_acc;
                    end
                end else begin
                    // broken escape: replay raw text
                    cand[0] = CHR_BSLASH;
                    cand[1] = (r_mode == MODE_HEX) ? CHR_X : CHR_U;
                    for (int i = 0; i < RAW_DIG; i++) begin
                        if (2'(i) < r_dc) begin
                            cand[2+i] = r_raw[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (pass_c && !c_bs) begin
            cand[5] = c;
        end
        // end of string flush
        if (i_in_last) begin
            case (n_mode)
                MODE_ESC: cand[6] = CHR_BSLASH;
                MODE_OCT: cand[6] = n_acc;
                MODE_HEX, MODE_UNI: begin
                    cand[6] = CHR_BSLASH;
                    cand[7] = (n_mode == MODE_HEX) ? CHR_X : CHR_U;
                    for (int i = 0; i < RAW_DIG; i++) begin
                        if (2'(i) < n_dc) begin
                            cand[8+i] = n_raw[i];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // compaction: drop zero bytes, pack the rest in order
    always_comb begin
        logic [NUM_CAND-1:0] lo;
        for (int i = 0; i < NUM_CAND; i++) begin
            cval[i] = (cand[i] != 8'h00);
        end
        for (int i = 0; i < NUM_CAND; i++) begin
            lo     = cval & ((NUM_CAND'(1) << i) - NUM_CAND'(1));
            pos[i] = 4'($countones(lo));
        end
        n_new = 3'($countones(cval));
        for (int k = 0; k < MAX_RES; k++) begin
            nres[k] = '0;
            for (int i = 0; i < NUM_CAND; i++) begin
                if (cval[i] && pos[i] == 4'(k)) begin
                    nres[k].data = cand[i];
                    nres[k].has  = 1'b1;
                end
            end
        end
        // bare end marker when nothing else comes out
        if (i_in_last && n_new == 3'd0) begin
            n_new = 3'd1;
        end
        for (int k = 0; k < MAX_RES; k++) begin
            nres[k].last = i_in_last && (3'(k) == n_new - 3'd1);
        end
    end

    // result queue: shift out at the head, append behind the survivors
    always_comb begin
        base = r_cnt - {3'd0, pop};
        for (int j = 0; j < Q_DEPTH - 1; j++) begin
            n_q[j] = pop ? r_q[j+1] : r_q[j];
        end
        n_q[Q_DEPTH-1] = r_q[Q_DEPTH-1];
        for (int j = 0; j < Q_DEPTH; j++) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (accept && 3'(k) < n_new && 4'(j) == base + 4'(k)) begin
                    n_q[j] = nres[k];
                end
            end
        end
        n_cnt = base + (accept ? {1'b0, n_new} : 4'd0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_dc   <= 2'd0;
            r_acc  <= 8'h00;
            r_fol  <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_mode <= i_in_last ? MODE_NORMAL : n_mode;
                r_dc   <= n_dc;
                r_acc  <= n_acc;
                r_fol  <= n_fol;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (accept) begin
            r_raw <= n_raw;
        end
    end

endmodule

`default_nettype wire

/* sim/tb_escape_sequence_decoder.sv */
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder - testbench for the escape sequence decoder
// Streams strings of raw characters through the block and checks every decoded
// result against a cycle-free decoder written in the bench. Covers letter,
// octal, hex and unicode escapes, broken and truncated escapes, zero bytes
// and end-of-string flushing, with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_escape_sequence_decoder
    import esd_pkg::*;
();

    // Decoder predictor plus expected result store
    class escape_scoreboard;
        t_mode       mode;
        logic [2:0]  ndig;
        logic [15:0] acc;
        logic [7:0]  raw [5];
        logic        oct_low;
        t_res        expected_q [$];
        t_res        burst [$];
        int          errors;
        int          n_checked;

        function new();
            mode      = MODE_NORMAL;
            ndig      = 3'd0;
            acc       = 16'd0;
            oct_low   = 1'b0;
            errors    = 0;
            n_checked = 0;
            foreach (raw[i]) raw[i] = 8'h00;
        endfunction

        // Zero bytes are dropped; at most MAX_RES results per character
        function void emit(logic [7:0] c);
            t_res r;
            if (c != 8'h00 && burst.size() < MAX_RES) begin
                r.data = c;
                r.has  = 1'b1;
                r.last = 1'b0;
                burst.push_back(r);
            end
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        // Backslash, letter and the digits taken so far
        function void replay_raw();
            int n;
            n = 2 + int'(ndig);
            if (n > 5) n = 5;
            for (int i = 0; i < n; i++) emit(raw[i]);
        endfunction

        function void decode_char(logic [7:0] c);
            logic again;
            int   h;
            int   need;
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (mode)
                    MODE_ESC: begin
                        mode = MODE_NORMAL;
                        case (c)
                            CHR_BSLASH: emit(CHR_BSLASH);
                            CHR_R:      emit(CTL_CR);
                            CHR_N:      emit(CTL_LF);
                            CHR_T:      emit(CTL_TAB);
                            CHR_V:      emit(CTL_VT);
                            CHR_A:      emit(CTL_BEL);
                            CHR_X, CHR_U: begin
                                mode   = (c == CHR_X) ? MODE_HEX : MODE_UNI;
                                raw[1] = c;
                                ndig   = 3'd0;
                                acc    = 16'd0;
                            end
                            default: begin
                                if (c >= "0" && c <= "7") begin
                                    mode    = MODE_OCT;
                                    acc     = 16'(c - "0");
                                    ndig    = 3'd1;
                                    oct_low = (c < "4");
                                end else begin
                                    // unknown letter: backslash, then the letter as is
                                    emit(CHR_BSLASH);
                                    emit(c);
                                end
                            end
                        endcase
                    end
                    MODE_OCT: begin
                        if (c >= "0" && c <= "7") begin
                            acc  = acc * 16'd8 + 16'(c - "0");
                            ndig = ndig + 3'd1;
                            if (int'(ndig) >= (oct_low ? 3 : 2)) begin
                                emit(acc[7:0]);
                                mode = MODE_NORMAL;
                            end
                        end else begin
                            // octal ended early; the character goes round again
                            emit(acc[7:0]);
                            mode  = MODE_NORMAL;
                            again = 1'b1;
                        end
                    end
                    MODE_HEX, MODE_UNI: begin
                        need = (mode == MODE_HEX) ? 2 : 4;
                        h    = hex_value(c);
                        if (h >= 0) begin
                            acc = {acc[11:0], 4'(h)};
                            if (int'(ndig) + 1 >= need) begin
                                emit(acc[7:0]);
                                mode = MODE_NORMAL;
                            end else begin
                                if (2 + int'(ndig) < 5) raw[2 + int'(ndig)] = c;
                                ndig = ndig + 3'd1;
                            end
                        end else begin
                            // broken escape: replay raw, then reparse the character
                            replay_raw();
                            mode  = MODE_NORMAL;
                            again = 1'b1;
                        end
                    end
                    default: begin
                        mode = MODE_NORMAL;
                        if (c == CHR_BSLASH) begin
                            mode   = MODE_ESC;
                            raw[0] = c;
                        end else begin
                            emit(c);
                        end
                    end
                endcase
            end
        endfunction

        // End of string: settle whatever escape is pending
        function void flush_escape();
            case (mode)
                MODE_ESC:           emit(CHR_BSLASH);
                MODE_OCT:           emit(acc[7:0]);
                MODE_HEX, MODE_UNI: replay_raw();
                default: ;
            endcase
            mode = MODE_NORMAL;
            ndig = 3'd0;
            acc  = 16'd0;
        endfunction

        // Accepted input transaction
        function void note_char(logic [7:0] c, logic last);
            t_res r;
            burst.delete();
            decode_char(c);
            if (last) begin
                flush_escape();
                if (burst.size() > 0) begin
                    r      = burst[burst.size() - 1];
                    r.last = 1'b1;
                    burst[burst.size() - 1] = r;
                end else begin
                    r.data = 8'h00;
                    r.has  = 1'b0;
                    r.last = 1'b1;
                    burst.push_back(r);
                end
            end
            foreach (burst[i]) expected_q.push_back(burst[i]);
        endfunction

        // Accepted output transaction
        function void check_result(logic [7:0] data, logic has, logic last);
            t_res exp_r;
            n_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: expected no result, actual data=%h has=%b last=%b",
                         $time, data, has, last);
                return;
            end
            exp_r = expected_q.pop_front();
            if (data !== exp_r.data) begin
                errors++;
                $display("%0t: out_byte expected %h actual %h", $time, exp_r.data, data);
            end
            if (has !== exp_r.has) begin
                errors++;
                $display("%0t: has_byte expected %b actual %b", $time, exp_r.has, has);
            end
            if (last !== exp_r.last) begin
                errors++;
                $display("%0t: out_last expected %b actual %b", $time, exp_r.last, last);
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic       o_out_last;

    escape_scoreboard sb = new();
    logic       idle_en   = 1'b1;
    logic [7:0] str_q [$];
    int         n_sent    = 0;
    int         n_strings = 0;

    escape_sequence_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_has_byte (o_has_byte),
        .o_out_last (o_out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side back-pressure in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 4) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_out_byte, o_has_byte, o_out_last);
    end

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'("0" + v);
        if (v < 16) return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    // Append one random token: plain byte, escape, or broken escape
    function automatic void add_token();
        int         kind;
        int         cnt;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            if ($urandom_range(0, 3) == 0) begin
                str_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == CHR_BSLASH) c = "_";
                str_q.push_back(c);
            end
        end else if (kind < 35) begin
            str_q.push_back(CHR_BSLASH);
            case ($urandom_range(0, 5))
                0: str_q.push_back(CHR_BSLASH);
                1: str_q.push_back(CHR_R);
                2: str_q.push_back(CHR_N);
                3: str_q.push_back(CHR_T);
                4: str_q.push_back(CHR_V);
                default: str_q.push_back(CHR_A);
            endcase
        end else if (kind < 40) begin
            str_q.push_back(CHR_BSLASH);
            str_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 60) begin
            str_q.push_back(CHR_BSLASH);
            cnt = $urandom_range(1, 3);
            repeat (cnt) str_q.push_back(8'("0" + $urandom_range(0, 7)));
        end else if (kind < 78) begin
            str_q.push_back(CHR_BSLASH);
            str_q.push_back(CHR_X);
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : 2;
            repeat (cnt) str_q.push_back(rand_hex_char());
        end else if (kind < 98) begin
            str_q.push_back(CHR_BSLASH);
            str_q.push_back(CHR_U);
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
            repeat (cnt) str_q.push_back(rand_hex_char());
        end else begin
            str_q.push_back(CHR_BSLASH);
        end
    endfunction

    // One input transaction, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_in_byte = c;
        i_in_last = last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_char(c, last);
        n_sent++;
    endtask

    // Send the queued string, marking its final character
    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_char(str_q[i], i == str_q.size() - 1);
        str_q.delete();
        n_strings++;
    endtask

    initial begin
        int ntok;
        int guard;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every letter escape, unknown letter, full octal, broken hex,
        // six-result replay flushed at the end, then a lone zero as end marker
        str_q = '{8'hFF, CHR_BSLASH, CHR_BSLASH, CHR_BSLASH, CHR_R, CHR_BSLASH, CHR_N,
                  CHR_BSLASH, CHR_T, CHR_BSLASH, CHR_V, CHR_BSLASH, CHR_A,
                  CHR_BSLASH, "q", CHR_BSLASH, "3", "7", "7",
                  CHR_BSLASH, CHR_X, "4", "G",
                  CHR_BSLASH, CHR_U, "1", "2", "3", CHR_BSLASH};
        send_string();
        send_char(8'h00, 1'b1);

        // Random strings of mostly well-formed escapes; no idling at the end
        while (n_sent < 250) begin
            ntok = $urandom_range(1, 8);
            repeat (ntok) add_token();
            if (n_sent >= 200) idle_en = 1'b0;
            send_string();
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        // Drain, then wait for anything stray
        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
        end

        $display("Summary: %0d characters in %0d strings sent, %0d results checked",
                 n_sent, n_strings, sb.n_checked);
        $display("Summary: letter, octal, hex and unicode escapes, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/esd_pkg.sv
design/escape_sequence_decoder.sv
sim/tb_escape_sequence_decoder.sv
